// ----- design/hash_multiset_table_assert.svh -----
// Assertion macros shared by the checking code of the hash multiset table.
// Each macro expects clk and rst to be visible at the place of use.
`ifndef HASH_MULTISET_TABLE_ASSERT_SVH
`define HASH_MULTISET_TABLE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HMS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication with the consequent checked in the same cycle.
`define HMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/hms_pkg.sv -----
`timescale 1ns / 1ps

package hms_pkg;

  localparam int KEY_BITS = 31;
  localparam int BUCKETS  = 15;
  localparam int WAYS     = 4;

  localparam int KIND_W = 2;
  localparam int ST_W   = 2;
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PROD_W = 2 * KEY_BITS + 1;
  localparam int ROW_W  = WAYS * KEY_BITS;

  // floor(2^KEY_BITS / BUCKETS); the quotient estimate is low by at most one
  localparam logic [KEY_BITS:0] RECIP = (KEY_BITS + 1)'((65'd1 << KEY_BITS) / BUCKETS);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [KEY_BITS-1:0] key;
    logic [BKT_W-1:0]    bucket;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- design/hms_if.sv -----
`timescale 1ns / 1ps

interface hms_req_if;
  import hms_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

interface hms_rsp_if;
  import hms_pkg::*;

  logic            valid;
  logic            ready;
  logic            hit;
  logic [ST_W-1:0] status;

  modport source (output valid, output hit, output status, input ready);
  modport sink (input valid, input hit, input status, output ready);
endinterface

// ----- design/hms_front.sv -----
`timescale 1ns / 1ps

module hms_front (
  input  logic          clk,
  input  logic          rst,
  hms_req_if.sink       req,
  input  hms_pkg::qstat_t qstat,
  output logic          push,
  output hms_pkg::req_t push_data
);
  import hms_pkg::*;

  logic                s1_valid;
  logic [KIND_W-1:0]   s1_kind;
  logic [KEY_BITS-1:0] s1_key;
  logic [PROD_W-1:0]   s1_prod;
  logic                s2_valid;
  req_t                s2;

  logic                advance;
  logic [KEY_BITS-1:0] quot;
  logic [KEY_BITS-1:0] rem;
  logic [KEY_BITS-1:0] rem_fix;

  // hold both stages while the queue cannot take the item in stage two
  assign advance   = !s2_valid || !qstat.full;
  assign req.ready = advance;
  assign push      = advance && s2_valid;
  assign push_data = s2;

  always_comb begin
    quot    = KEY_BITS'(s1_prod[PROD_W-1:KEY_BITS]);
    rem     = s1_key - KEY_BITS'(quot * BUCKETS);
    // quotient estimate may be one short: fold the remainder once
    rem_fix = (rem >= KEY_BITS'(BUCKETS)) ? rem - KEY_BITS'(BUCKETS) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind   <= req.kind;
      s1_key    <= req.key;
      s1_prod   <= req.key * RECIP;
      s2.kind   <= s1_kind;
      s2.key    <= s1_key;
      s2.bucket <= BKT_W'(rem_fix);
    end
  end

endmodule

// ----- design/hms_queue.sv -----
`timescale 1ns / 1ps

module hms_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hms_pkg::req_t   push_data,
  input  logic            pop,
  output hms_pkg::req_t   head,
  output hms_pkg::qstat_t qstat
);
  import hms_pkg::*;

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = entry[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

// ----- design/hms_back.sv -----
`timescale 1ns / 1ps

module hms_back (
  input  logic            clk,
  input  logic            rst,
  input  hms_pkg::req_t   head,
  input  hms_pkg::qstat_t qstat,
  output logic            pop,
  hms_rsp_if.source       rsp
);
  import hms_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic             state;
  req_t             cur;
  logic [ROW_W-1:0] key_mem [BUCKETS];
  logic [ROW_W-1:0] rd_row;
  logic [WAYS-1:0]  valid_row [BUCKETS];

  logic             out_valid;
  logic             out_hit;
  logic [ST_W-1:0]  out_status;

  logic             fire;
  logic [WAYS-1:0]  vrow;
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  match_low;
  logic [WAYS-1:0]  free_low;
  logic [WAYS-1:0]  vrow_next;
  logic [ROW_W-1:0] wr_row;
  logic             mem_we;
  logic             hit_next;
  logic [ST_W-1:0]  status_next;

  assign rsp.valid  = out_valid;
  assign rsp.hit    = out_hit;
  assign rsp.status = out_status;

  assign pop  = (state == S_IDLE) && !qstat.empty;
  // finish the lookup only when the output register is free or draining
  assign fire = (state == S_LOOK) && (!out_valid || rsp.ready);

  always_comb begin
    vrow = valid_row[cur.bucket];
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vrow[w] && (rd_row[w*KEY_BITS +: KEY_BITS] == cur.key);
    end
    match_low = match & (~match + WAYS'(1));
    free_low  = ~vrow & (vrow + WAYS'(1));
    for (int w = 0; w < WAYS; w++) begin
      wr_row[w*KEY_BITS +: KEY_BITS] =
        free_low[w] ? cur.key : rd_row[w*KEY_BITS +: KEY_BITS];
    end

    vrow_next   = vrow;
    mem_we      = 1'b0;
    hit_next    = 1'b0;
    status_next = ST_MISSING;
    case (cur.kind)
      KIND_INSERT: begin
        if (|free_low) begin
          vrow_next   = vrow | free_low;
          mem_we      = fire;
          hit_next    = 1'b1;
          status_next = ST_OK;
        end else begin
          status_next = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (|match) begin
          vrow_next   = vrow & ~match_low;
          hit_next    = 1'b1;
          status_next = ST_OK;
        end
      end
      KIND_FIND: begin
        if (|match) begin
          hit_next    = 1'b1;
          status_next = ST_OK;
        end
      end
      default: begin
        hit_next    = 1'b0;
        status_next = ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        valid_row[b] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) state <= S_LOOK;
        end
        S_LOOK: begin
          if (fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (fire) begin
        out_valid            <= 1'b1;
        valid_row[cur.bucket] <= vrow_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (fire) begin
      out_hit    <= hit_next;
      out_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) key_mem[cur.bucket] <= wr_row;
    if (pop) rd_row <= key_mem[head.bucket];
  end

endmodule

// ----- design/hash_multiset_table.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req     | in  | valid/ready | kind[1:0], key[30:0]
// rsp     | out | valid/ready | hit, status[1:0]
//
// A request enters a two-stage front pipeline that finds its bucket by a
// reciprocal multiply and one correction, then waits in a two-entry queue.
// The back handles one request at a time (bucket row read, then compare of all
// ways and write-back) and pops no new request until the last one is done;
// the compare and write-back also wait while the output register is held.
// Reset clears the valid marks at once; the key store needs no clearing pass.
// A stalled result holds in the output register; the front keeps accepting
// until the queue and its own stages fill.

`include "hash_multiset_table_assert.svh"

module hash_multiset_table (
  input  logic      clk,
  input  logic      rst,
  hms_req_if.sink   req,
  hms_rsp_if.source rsp
);
  import hms_pkg::*;

  logic   q_push;
  req_t   q_push_data;
  logic   q_pop;
  req_t   q_head;
  qstat_t q_stat;

  hms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .qstat     (q_stat),
    .push      (q_push),
    .push_data (q_push_data)
  );

  hms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .qstat     (q_stat)
  );

  hms_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .qstat (q_stat),
    .pop   (q_pop),
    .rsp   (rsp)
  );

  `HMS_ASSERT_IMPL(a_no_push_full, q_push && q_stat.full, q_pop, "push into full queue")
  `HMS_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_stat.empty, "pop from empty queue")
  `HMS_ASSERT_IMPL(a_hit_ok, rsp.valid, rsp.hit == (rsp.status == ST_OK), "hit and status disagree")
  `HMS_ASSERT_IMPL(a_status_code, rsp.valid, rsp.status == ST_OK || rsp.status == ST_MISSING || rsp.status == ST_FULL, "bad status code")

endmodule
